// ===== design/lpfr_pkg.sv =====
// Shared types and constants for the LRU page frame replacer.
// Used by the channel interfaces, the frame cell and the top level.
`default_nettype none

package lpfr_pkg;

    localparam int IN_PAGE_W   = 16;
    localparam int OUT_PAGE_W  = 16;
    localparam int OUT_SLOT_W  = 3;
    localparam int CFG_W       = 4;
    localparam int STAMP_W     = 32;
    localparam int COUNT_W     = 32;
    // Widest slot index and page number that any legal configuration needs.
    localparam int SLOT_MAX_W  = 6;
    localparam int PAGE_MAX_W  = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Running result that travels down the row of frame cells.
    typedef struct packed {
        logic                  empty;
        logic                  hit;
        logic                  valid;
        logic [SLOT_MAX_W-1:0] slot;
        logic [STAMP_W-1:0]    stamp;
        logic [PAGE_MAX_W-1:0] page;
    } lpfr_carry_t;

    // Update broadcast to all cells when a reference completes.
    typedef struct packed {
        logic                  en;
        logic                  fill;
        logic [SLOT_MAX_W-1:0] slot;
        logic [STAMP_W-1:0]    stamp;
        logic [PAGE_MAX_W-1:0] page;
    } lpfr_wr_t;

endpackage

`default_nettype wire

// ===== design/lpfr_if.sv =====
// Valid/ready channel interfaces of the LRU page frame replacer.
// Depends on lpfr_pkg for the field widths.
`default_nettype none

interface lpfr_req_if;
    import lpfr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [IN_PAGE_W-1:0] page_number;
    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface lpfr_rsp_if;
    import lpfr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  is_hit;
    logic [OUT_SLOT_W-1:0] slot_used;
    logic                  evicted_valid;
    logic [OUT_PAGE_W-1:0] evicted_page;
    logic [COUNT_W-1:0]    fault_total;
    modport source (output valid, output is_hit, output slot_used, output evicted_valid,
                    output evicted_page, output fault_total, input ready);
    modport sink   (input valid, input is_hit, input slot_used, input evicted_valid,
                    input evicted_page, input fault_total, output ready);
endinterface

interface lpfr_cfg_if;
    import lpfr_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] active_frames;
    modport source (output valid, output active_frames, input ready);
    modport sink   (input valid, input active_frames, output ready);
endinterface

`default_nettype wire

// ===== design/lru_page_frame_replacer.sv =====
// LRU page frame replacer.
// Channels: req carries one page reference (page_number) per transfer; rsp
// returns one result per reference (is_hit, slot_used, evicted_valid,
// evicted_page, fault_total); cfg writes active_frames at any transfer and is
// always ready. Configure only while no reference is in flight.
// Each frame is a cell in a row. The cells hand a running search result to
// their right neighbor every cycle, one frame per cycle, and the search of a
// reference ends when its result leaves the last cell of the row.
// req.ready is high only between references, so the block takes no new
// reference until the last one has reached the output register; the length
// of the cell row sets how long the search lasts.
// The result sits in an output register; the next reference is accepted
// while it waits. If rsp is still stalled when the following search ends,
// the block holds that search, and req stays low, until the register frees.
// Reset empties all frames, clears stamps and both counters, and sets
// active_frames to 8. The block is ready as soon as reset is released.
// An active_frames of zero acts as one; values above FRAMES act as FRAMES.
`default_nettype none

module lru_page_frame_replacer #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lpfr_req_if.sink   req,
    lpfr_rsp_if.source rsp,
    lpfr_cfg_if.sink   cfg
);
    import lpfr_pkg::*;

    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(FRAMES);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic                  state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CFG_W-1:0]      cfg_reg;
    logic [PAGE_BITS-1:0]  key_reg;
    logic [COUNT_W-1:0]    ref_reg, ref_next;
    logic [COUNT_W-1:0]    fault_reg, fault_next;

    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [OUT_SLOT_W-1:0] out_slot_reg;
    logic                  out_ev_valid_reg;
    logic [OUT_PAGE_W-1:0] out_ev_page_reg;

    lpfr_carry_t           carry [0:FRAMES];
    lpfr_carry_t           fin;
    lpfr_wr_t              wr;
    logic [FRAMES-1:0]     active;
    logic                  accept;
    logic                  commit;
    logic [IN_PAGE_W+PAGE_BITS-1:0] page_ext;

    assign page_ext = {{PAGE_BITS{1'b0}}, req.page_number};
    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign carry[0] = '{empty: 1'b1, hit: 1'b0, valid: 1'b0, slot: '0, stamp: '0, page: '0};
    assign fin      = carry[FRAMES];
    assign commit   = (state_reg == ST_BUSY) && (cnt_reg == CNT_DONE)
                      && (!out_valid_reg || rsp.ready);

    genvar k;
    generate
        for (k = 0; k < FRAMES; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                assign active[k] = 1'b1;
            end
            else
            begin : g_tail
                assign active[k] = ({28'd0, cfg_reg} > 32'(k));
            end
            lpfr_cell #(
                .INDEX     (k),
                .PAGE_BITS (PAGE_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .active    (active[k]),
                .key       (key_reg),
                .wr        (wr),
                .carry_in  (carry[k]),
                .carry_out (carry[k+1])
            );
        end
    endgenerate

    always_comb
    begin
        ref_next   = (ref_reg == COUNT_MAX) ? ref_reg : ref_reg + 1'b1;
        fault_next = (fault_reg == COUNT_MAX) ? fault_reg : fault_reg + 1'b1;
        wr.en      = commit;
        wr.fill    = !fin.hit;
        wr.slot    = fin.slot;
        wr.stamp   = ref_next;
        wr.page    = PAGE_MAX_W'(key_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_BUSY;
                    cnt_next   = '0;
                end
            end
            ST_BUSY:
            begin
                if (cnt_reg != CNT_DONE)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cfg_reg       <= CFG_RESET;
            ref_reg       <= '0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg.valid)
            begin
                cfg_reg <= cfg.active_frames;
            end
            if (commit)
            begin
                ref_reg       <= ref_next;
                out_valid_reg <= 1'b1;
                if (!fin.hit)
                begin
                    fault_reg <= fault_next;
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= page_ext[PAGE_BITS-1:0];
        end
        if (commit)
        begin
            out_hit_reg      <= fin.hit;
            out_slot_reg     <= fin.slot[OUT_SLOT_W-1:0];
            out_ev_valid_reg <= !fin.hit && fin.valid;
            out_ev_page_reg  <= (!fin.hit && fin.valid) ? fin.page[OUT_PAGE_W-1:0] : '0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.is_hit        = out_hit_reg;
    assign rsp.slot_used     = out_slot_reg;
    assign rsp.evicted_valid = out_ev_valid_reg;
    assign rsp.evicted_page  = out_ev_page_reg;
    assign rsp.fault_total   = fault_reg;

endmodule

`default_nettype wire

// ===== design/lpfr_cell.sv =====
// One page frame: page number, valid mark and last-use stamp, plus one stage
// of the hit/LRU search chain. Depends on lpfr_pkg.
`default_nettype none

module lpfr_cell #(
    parameter int INDEX     = 0,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   active,
    input  wire logic [PAGE_BITS-1:0]   key,
    input  wire lpfr_pkg::lpfr_wr_t     wr,
    input  wire lpfr_pkg::lpfr_carry_t  carry_in,
    output lpfr_pkg::lpfr_carry_t       carry_out
);
    import lpfr_pkg::*;

    localparam logic [SLOT_MAX_W-1:0] MY_SLOT = SLOT_MAX_W'(INDEX);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic [STAMP_W-1:0]   stamp_reg;
    lpfr_carry_t          carry_reg;
    lpfr_carry_t          carry_next;
    logic                 match;
    logic                 wr_here;

    assign match   = active && valid_reg && (page_reg == key);
    assign wr_here = wr.en && (wr.slot == MY_SLOT);

    // The first matching frame wins; otherwise the strictly older stamp wins,
    // so equal stamps stay with the lower index.
    always_comb
    begin
        carry_next = carry_in;
        if (carry_in.hit)
        begin
            carry_next = carry_in;
        end
        else if (match)
        begin
            carry_next.empty = 1'b0;
            carry_next.hit   = 1'b1;
            carry_next.slot  = MY_SLOT;
        end
        else if (active && (carry_in.empty || (stamp_reg < carry_in.stamp)))
        begin
            carry_next.empty = 1'b0;
            carry_next.hit   = 1'b0;
            carry_next.valid = valid_reg;
            carry_next.slot  = MY_SLOT;
            carry_next.stamp = stamp_reg;
            carry_next.page  = PAGE_MAX_W'(page_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg  <= '0;
            valid_reg <= 1'b0;
            stamp_reg <= '0;
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
            if (wr_here)
            begin
                stamp_reg <= wr.stamp;
                if (wr.fill)
                begin
                    page_reg  <= wr.page[PAGE_BITS-1:0];
                    valid_reg <= 1'b1;
                end
            end
        end
    end

    assign carry_out = carry_reg;

endmodule

`default_nettype wire

// ===== design/lpfr_checker.sv =====
// Port-level checks for the LRU page frame replacer, bound to the top level.
// Depends on lpfr_pkg for the field widths.
`default_nettype none

module lpfr_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_ready,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_ready,
    input wire logic                            rsp_is_hit,
    input wire logic                            rsp_evicted_valid,
    input wire logic [lpfr_pkg::OUT_PAGE_W-1:0] rsp_evicted_page,
    input wire logic [lpfr_pkg::COUNT_W-1:0]    rsp_fault_total
);
    import lpfr_pkg::*;

    // A reference is searched through the whole cell row, so the next transfer
    // cannot follow directly.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted in back-to-back cycles");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_hit |-> !rsp_evicted_valid)
        else $error("hit reports an evicted page");

    a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_evicted_valid |-> rsp_evicted_page == '0)
        else $error("evicted page nonzero without an eviction");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fault_total)
                                    && $stable(rsp_is_hit))
        else $error("stalled result changed");

endmodule

bind lru_page_frame_replacer lpfr_checker u_lpfr_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_is_hit        (rsp.is_hit),
    .rsp_evicted_valid (rsp.evicted_valid),
    .rsp_evicted_page  (rsp.evicted_page),
    .rsp_fault_total   (rsp.fault_total)
);

`default_nettype wire
